>>> rtl/core/ordered_array_table_engine_assert.svh
// assertion macros for the table engine rtl
`ifndef ORDERED_ARRAY_TABLE_ENGINE_ASSERT_SVH
`define ORDERED_ARRAY_TABLE_ENGINE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define OATE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define OATE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/oate_pkg.sv
// shared types and constants of the ordered table engine
package oate_pkg;

  localparam int DEPTH = 128;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OP_W  = 3;
  localparam int POS_W = 8;
  localparam int VAL_W = 32;
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd4;
  localparam logic [OP_W-1:0] OP_READ   = 3'd5;

  typedef logic signed [VAL_W-1:0] word_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DONE = 1'b1
  } state_t;

  // per-cell controls for one beat
  typedef struct packed {
    logic load_val;   // take the broadcast value
    logic take_prev;  // shift up: take left neighbor
    logic take_next;  // shift down: take right neighbor
    logic live;       // cell holds a valid entry and a search is running
    logic sample;     // capture compare result
    logic rd_sel;     // drive entry onto the read bus
  } cell_ctl_t;

endpackage

>>> rtl/core/oate_if.sv
// handshake channels of the ordered table engine
interface oate_in_if
  import oate_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [POS_W-1:0]    position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

interface oate_out_if
  import oate_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic [POS_W-1:0]        found_position;
  logic signed [VAL_W-1:0] read_value;
  logic [POS_W-1:0]        entry_total;
  logic [1:0]              status;

  modport source (output valid, output found, output found_position, output read_value,
                  output entry_total, output status, input ready);
  modport sink   (input valid, input found, input found_position, input read_value,
                  input entry_total, input status, output ready);
endinterface

>>> rtl/core/oate_cell.sv
// one table cell: holds an entry, shifts with its neighbors, compares
module oate_cell
  import oate_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  word_t     val,
  input  word_t     prev_data,
  input  word_t     next_data,
  output word_t     data,
  output word_t     rd_data,
  output logic      hit
);

  word_t entry_r;
  word_t entry_nxt;
  logic  hit_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load_val) begin
      entry_nxt = val;
    end else if (ctl.take_prev) begin
      entry_nxt = prev_data;
    end else if (ctl.take_next) begin
      entry_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctl.sample) begin
      hit_r <= ctl.live && (entry_r == val);
    end
  end

  assign data    = entry_r;
  assign rd_data = ctl.rd_sel ? entry_r : '0;
  assign hit     = hit_r;

endmodule

>>> rtl/core/oate_first_hit.sv
// log-depth first-set finder over the cell hit flags
module oate_first_hit
  import oate_pkg::*;
(
  input  logic [DEPTH-1:0] hit,
  output logic             any,
  output logic [IDX_W-1:0] idx
);

  localparam int NP = 1 << IDX_W;

  logic             v_l [IDX_W+1][NP];
  logic [IDX_W-1:0] i_l [IDX_W+1][NP];

  always_comb begin
    for (int l = 0; l <= IDX_W; l++) begin
      for (int k = 0; k < NP; k++) begin
        v_l[l][k] = 1'b0;
        i_l[l][k] = '0;
      end
    end
    for (int k = 0; k < NP; k++) begin
      if (k < DEPTH) begin
        v_l[0][k] = hit[k];
      end
      i_l[0][k] = IDX_W'(k);
    end
    // lower index wins at each pair
    for (int l = 0; l < IDX_W; l++) begin
      for (int k = 0; k < NP / 2; k++) begin
        if (k < (NP >> (l + 1))) begin
          v_l[l+1][k] = v_l[l][2*k] || v_l[l][2*k+1];
          i_l[l+1][k] = v_l[l][2*k] ? i_l[l][2*k] : i_l[l][2*k+1];
        end
      end
    end
  end

  assign any = v_l[IDX_W][0];
  assign idx = i_l[IDX_W][0];

endmodule

>>> rtl/core/ordered_array_table_engine.sv
// top level of the ordered table engine: cell row, control and result register
// Ordered table of DEPTH signed 32-bit words held in a row of cells, one word
// per cell, with a live entry count. Each input beat carries one operation:
// append, search, insert at a 1-based position, delete at a position,
// overwrite at a position, or read at a position. On the accept edge every
// cell compares its word against the broadcast value and the whole row
// shifts up (insert) or down (delete) at once, so no operation iterates.
// Once the output register is free, a log-depth first-hit finder turns the
// registered compare flags into the search position and the result beat is
// loaded into the output register. A new beat is accepted in the same cycle
// as a result is loaded, so one operation per clock is sustained while the
// consumer keeps up. The rate is set by the cell row updating all at once
// and the output register being free. Rejected operations (bad position,
// full, empty) change nothing and report status; codes 6 and 7 do nothing
// and report ok. entry_total is the count after the operation, reported in
// its low 8 bits. Cell contents are not reset; only entries below the count
// are ever read.
`include "ordered_array_table_engine_assert.svh"

module ordered_array_table_engine
  import oate_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  oate_in_if.sink    in_ch,
  oate_out_if.source out_ch
);

  // control state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // latched per-beat results
  status_t          status_r;
  word_t            rval_r;

  // output register
  logic             out_valid_r;
  logic             out_found_r;
  logic [POS_W-1:0] out_fpos_r;
  word_t            out_rval_r;
  logic [POS_W-1:0] out_total_r;
  status_t          out_status_r;

  logic             fire;
  logic             out_free;
  logic             load_out;

  // request decode
  logic [CMP_W-1:0] posx, cntx, pidx;
  logic             full, empty, ins_bad, pos_bad;
  status_t          st;
  logic             app_ok, srch, ins_ok, del_ok, wr_ok, rd_ok;

  // cell row
  cell_ctl_t        ctl     [DEPTH];
  word_t            data    [DEPTH];
  word_t            prev_d  [DEPTH];
  word_t            next_d  [DEPTH];
  word_t            rd_d    [DEPTH];
  logic [DEPTH-1:0] hits;
  word_t            rd_bus;

  logic             enc_any;
  logic [IDX_W-1:0] enc_idx;
  logic [CMP_W-1:0] fpos_w;
  logic [CMP_W-1:0] total_w;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) || out_free;
  assign fire = in_ch.valid && in_ch.ready;
  assign load_out = (state_r == S_DONE) && out_free;

  // position and count checks
  assign posx = CMP_W'(in_ch.position);
  assign cntx = CMP_W'(count_r);
  assign pidx = posx - CMP_W'(1);
  assign full = (count_r >= CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign ins_bad = (in_ch.position == '0) || (posx > cntx + CMP_W'(1));
  assign pos_bad = (in_ch.position == '0) || (posx > cntx);

  always_comb begin
    st = ST_OK;
    case (in_ch.operation) inside
      OP_APPEND: begin
        if (full) st = ST_FULL;
      end
      OP_SEARCH: begin
        if (empty) st = ST_EMPTY;
      end
      OP_INSERT: begin
        if (full) st = ST_FULL;
        else if (ins_bad) st = ST_BADPOS;
      end
      OP_DELETE, OP_WRITE, OP_READ: begin
        if (empty) st = ST_EMPTY;
        else if (pos_bad) st = ST_BADPOS;
      end
      default: st = ST_OK;
    endcase
  end

  // operations that go ahead on this beat
  assign app_ok = fire && (in_ch.operation == OP_APPEND) && (st == ST_OK);
  assign srch   = fire && (in_ch.operation == OP_SEARCH);
  assign ins_ok = fire && (in_ch.operation == OP_INSERT) && (st == ST_OK);
  assign del_ok = fire && (in_ch.operation == OP_DELETE) && (st == ST_OK);
  assign wr_ok  = fire && (in_ch.operation == OP_WRITE) && (st == ST_OK);
  assign rd_ok  = fire && (in_ch.operation == OP_READ) && (st == ST_OK);

  // per-cell controls and neighbor links
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CMP_W-1:0] CIDX = CMP_W'(i);

    always_comb begin
      ctl[i].load_val  = (app_ok && (CIDX == cntx)) ||
                         ((ins_ok || wr_ok) && (CIDX == pidx));
      ctl[i].take_prev = ins_ok && (CIDX > pidx);
      ctl[i].take_next = del_ok && (CIDX >= pidx);
      ctl[i].live      = srch && (CIDX < cntx);
      ctl[i].sample    = fire;
      ctl[i].rd_sel    = (CIDX == pidx);
    end

    if (i == 0) begin : g_first
      assign prev_d[i] = '0;
    end else begin : g_prev
      assign prev_d[i] = data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_d[i] = '0;
    end else begin : g_next
      assign next_d[i] = data[i+1];
    end

    oate_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .val       (in_ch.value),
      .prev_data (prev_d[i]),
      .next_data (next_d[i]),
      .data      (data[i]),
      .rd_data   (rd_d[i]),
      .hit       (hits[i])
    );
  end

  // read bus: only the addressed cell drives it
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_bus = rd_bus | rd_d[k];
    end
  end

  oate_first_hit u_first_hit (
    .hit (hits),
    .any (enc_any),
    .idx (enc_idx)
  );

  assign fpos_w  = CMP_W'(enc_idx) + CMP_W'(1);
  assign total_w = CMP_W'(count_r);

  // count update
  always_comb begin
    count_nxt = count_r;
    if (app_ok || ins_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (del_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // sequencer: accept edge, then result load
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (fire) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = fire ? S_DONE : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // per-beat payload
  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= st;
      rval_r   <= rd_ok ? rd_bus : '0;
    end
    if (load_out) begin
      out_found_r  <= enc_any;
      out_fpos_r   <= enc_any ? fpos_w[POS_W-1:0] : '0;
      out_rval_r   <= rval_r;
      out_total_r  <= total_w[POS_W-1:0];
      out_status_r <= status_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.found          = out_found_r;
  assign out_ch.found_position = out_fpos_r;
  assign out_ch.read_value     = out_rval_r;
  assign out_ch.entry_total    = out_total_r;
  assign out_ch.status         = out_status_r;

  // checks
  `OATE_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "count above depth")
  `OATE_ASSERT_NXT(a_grow, app_ok || ins_ok, count_r == $past(count_r) + CNT_W'(1), "count did not grow")
  `OATE_ASSERT_NXT(a_shrink, del_ok, count_r == $past(count_r) - CNT_W'(1), "count did not shrink")
  `OATE_ASSERT_NXT(a_load, load_out, out_valid_r, "result beat not loaded")
  `OATE_ASSERT_IMP(a_found_ok, out_valid_r && out_found_r, out_status_r == ST_OK, "hit with error status")

endmodule

>>> tb/tb_top.sv
// self-checking bench for the ordered table engine: directed and random operation beats
module tb_top;
  import oate_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // codes 6 and 7 are unused by the engine and must act as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  localparam int IDLE_PCT   = 37;
  localparam int ITEM_GOAL  = 1950;
  localparam int CALM_FIRST = 700;   // accepted-beat window with no idling on either side
  localparam int CALM_LAST  = 1000;
  localparam int TAIL_WAIT  = 10;

  // one pending operation beat; settle_first holds it back until the engine has drained
  typedef struct {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    word_t            val;
    bit               settle_first;
  } op_beat_t;

  // what the engine should report for one operation
  typedef struct {
    logic             found;
    logic [POS_W-1:0] found_pos;
    word_t            rd_val;
    logic [POS_W-1:0] total;
    status_t          status;
  } table_result_t;

  logic clk;
  logic rst_n;

  oate_in_if  in_ch ();
  oate_out_if out_ch ();

  ordered_array_table_engine uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  op_beat_t      op_queue[$];      // beats waiting for the driver
  table_result_t results_due[$];   // predicted results, oldest first

  // predictor state: mirror of the table contents and live count
  word_t       tbl_words[DEPTH];
  int unsigned tbl_count;

  // stimulus planning: count after every queued beat, and values worth searching for
  int    plan_count;
  word_t value_pool[$];

  int beats_in;       // accepted operation beats, updated at the edge
  int results_got;    // accepted result beats, updated at the edge
  int fails;
  int op_seen[8];
  int status_seen[4];
  int search_hits;
  int peak_count;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // no idling inside this window of accepted beats
  function automatic bit calm_window();
    return (beats_in >= CALM_FIRST) && (beats_in < CALM_LAST);
  endfunction

  // apply one operation to the mirror table and return what the engine must report
  function automatic table_result_t apply_op(input logic [OP_W-1:0] op,
                                             input logic [POS_W-1:0] pos,
                                             input word_t val);
    table_result_t r;
    int unsigned   p;
    int            i;
    r.found     = 1'b0;
    r.found_pos = '0;
    r.rd_val    = '0;
    r.status    = ST_OK;
    p = pos;
    case (op)
      OP_APPEND: begin
        if (tbl_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          tbl_words[tbl_count] = val;
          tbl_count++;
        end
      end
      OP_SEARCH: begin
        if (tbl_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // first matching entry wins
          for (i = 0; i < tbl_count; i++) begin
            if (tbl_words[i] == val) begin
              r.found     = 1'b1;
              r.found_pos = POS_W'(i + 1);
              break;
            end
          end
        end
      end
      OP_INSERT: begin
        if (tbl_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (p < 1 || p > tbl_count + 1) begin
          r.status = ST_BADPOS;
        end else begin
          // later entries move up by one
          for (i = tbl_count; i > p - 1; i--) tbl_words[i] = tbl_words[i-1];
          tbl_words[p-1] = val;
          tbl_count++;
        end
      end
      OP_DELETE, OP_WRITE, OP_READ: begin
        if (tbl_count == 0) begin
          r.status = ST_EMPTY;
        end else if (p < 1 || p > tbl_count) begin
          r.status = ST_BADPOS;
        end else if (op == OP_DELETE) begin
          // later entries move down by one
          for (i = p - 1; i + 1 < tbl_count; i++) tbl_words[i] = tbl_words[i+1];
          tbl_count--;
        end else if (op == OP_WRITE) begin
          tbl_words[p-1] = val;
        end else begin
          r.rd_val = tbl_words[p-1];
        end
      end
      default: begin
        // spare codes: nothing happens, status ok
      end
    endcase
    r.total = POS_W'(tbl_count);
    return r;
  endfunction

  // queue one beat and track the count it leads to
  task automatic put(input logic [OP_W-1:0] op, input int pos, input word_t val,
                     input bit settle = 1'b0);
    op_beat_t b;
    b.op           = op;
    b.pos          = pos[POS_W-1:0];
    b.val          = val;
    b.settle_first = settle;
    op_queue.push_back(b);
    case (op)
      OP_APPEND: if (plan_count < DEPTH) plan_count++;
      OP_INSERT: if (plan_count < DEPTH && pos >= 1 && pos <= plan_count + 1) plan_count++;
      OP_DELETE: if (plan_count > 0 && pos >= 1 && pos <= plan_count) plan_count--;
      default: ;
    endcase
    if (op == OP_APPEND || op == OP_INSERT || op == OP_WRITE) begin
      value_pool.push_back(val);
      if (value_pool.size() > 48) void'(value_pool.pop_front());
    end
  endtask

  // often values already stored (search hits), some small ones (duplicates), extremes, else random words
  function automatic word_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35 && value_pool.size() > 0)
      return value_pool[$urandom_range(0, value_pool.size() - 1)];
    if (r < 55) return word_t'($urandom_range(0, 7));
    if (r < 58) return 32'sh8000_0000;
    if (r < 61) return 32'sh7FFF_FFFF;
    return word_t'($urandom);
  endfunction

  // mostly legal positions, with a share of anything the field can hold
  function automatic int pick_pos(input logic [OP_W-1:0] op);
    int hi;
    if ($urandom_range(0, 99) < 18) return $urandom_range(0, 255);
    if (op == OP_INSERT) begin
      hi = (plan_count < DEPTH) ? plan_count + 1 : DEPTH;
      return $urandom_range(1, hi);
    end
    if (plan_count == 0) return $urandom_range(0, 3);
    return $urandom_range(1, plan_count);
  endfunction

  // one random beat; the op mix leans toward keeping the count inside the table
  task automatic put_mixed();
    int r;
    int grow;
    int shrink;
    logic [OP_W-1:0] op;
    r = $urandom_range(0, 99);
    if (plan_count < 16) begin
      grow = 45; shrink = 10;
    end else if (plan_count > 110) begin
      grow = 10; shrink = 45;
    end else begin
      grow = 25; shrink = 25;
    end
    if (r < 5) begin
      op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
    end else begin
      r = $urandom_range(0, 99);
      if (r < grow) op = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
      else if (r < grow + shrink) op = OP_DELETE;
      else begin
        case ($urandom_range(0, 2))
          0:       op = OP_SEARCH;
          1:       op = OP_WRITE;
          default: op = OP_READ;
        endcase
      end
    end
    put(op, pick_pos(op), pick_value());
  endtask

  // fill the table to the top, poke it while full, then empty it again
  task automatic put_fill_drain();
    int p;
    put(OP_APPEND, 1, pick_value(), 1'b1);   // wait for the engine to drain first
    while (plan_count < DEPTH) begin
      case ($urandom_range(0, 4))
        0: put(OP_SEARCH, 1, pick_value());
        1: put(OP_INSERT, $urandom_range(1, plan_count + 1), pick_value());
        2: put(OP_READ, $urandom_range(1, plan_count), 0);
        default: put(OP_APPEND, $urandom_range(1, 255), pick_value());
      endcase
    end
    // full table: growth is refused, the last position is legal, one beyond is not
    put(OP_APPEND, 1, pick_value());
    put(OP_INSERT, 1, pick_value());
    put(OP_INSERT, DEPTH + 1, pick_value());
    put(OP_WRITE, DEPTH, word_t'($urandom));
    put(OP_READ, DEPTH, 0);
    put(OP_READ, DEPTH + 1, 0);
    put(OP_SEARCH, 1, pick_value());
    put(OP_DELETE, 255, 0);
    while (plan_count > 0) begin
      p = $urandom_range(1, plan_count);
      case ($urandom_range(0, 4))
        0: put(OP_SEARCH, p, pick_value());
        1: put(OP_WRITE, p, pick_value());
        default: put(OP_DELETE, p, 0);
      endcase
    end
    // empty again: search, read, write and delete report empty, insert at 2 a bad position
    put(OP_SEARCH, 1, pick_value());
    put(OP_READ, 1, 0);
    put(OP_WRITE, 1, pick_value());
    put(OP_DELETE, 1, 0);
    put(OP_INSERT, 2, pick_value());
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // driver: holds a beat until it is taken, then maybe idles before the next
  always @(posedge clk) begin
    bit            took;
    bit            launch;
    op_beat_t      nxt;
    table_result_t r;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      took = in_ch.valid && in_ch.ready;
      if (took) begin
        r = apply_op(in_ch.operation, in_ch.position, in_ch.value);
        results_due.push_back(r);
        op_seen[in_ch.operation]++;
        status_seen[r.status]++;
        if (r.found) search_hits++;
        if (tbl_count > peak_count) peak_count = tbl_count;
        beats_in <= beats_in + 1;
      end
      if (!in_ch.valid || took) begin
        launch = 1'b0;
        if (op_queue.size() > 0) begin
          if (op_queue[0].settle_first && (beats_in + took != results_got)) begin
            launch = 1'b0;   // hold off until every result is back
          end else if (!calm_window() && $urandom_range(0, 99) < IDLE_PCT) begin
            launch = 1'b0;
          end else begin
            launch = 1'b1;
          end
        end
        if (launch) begin
          nxt = op_queue.pop_front();
          in_ch.operation <= nxt.op;
          in_ch.position  <= nxt.pos;
          in_ch.value     <= nxt.val;
          in_ch.valid     <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result beat against the oldest prediction, stalls at random
  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_got <= results_got + 1;
        if (results_due.size() == 0) begin
          fails++;
          $display("%0t: result beat with nothing outstanding, expected none, got status %0d",
                   $time, out_ch.status);
        end else begin
          want = results_due.pop_front();
          check_field("found", want.found, out_ch.found);
          check_field("found_position", want.found_pos, out_ch.found_position);
          check_field("read_value", want.rd_val, out_ch.read_value);
          check_field("entry_total", want.total, out_ch.entry_total);
          check_field("status", want.status, out_ch.status);
        end
      end
      out_ch.ready <= calm_window() ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // stimulus, reset and end of run
  initial begin
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_APPEND;
    in_ch.position  = '0;
    in_ch.value     = '0;
    out_ch.ready    = 1'b0;
    rst_n           = 1'b0;
    tbl_count       = 0;
    plan_count      = 0;
    beats_in        = 0;
    results_got     = 0;
    fails           = 0;
    search_hits     = 0;
    peak_count      = 0;
    foreach (tbl_words[i]) tbl_words[i] = '0;
    foreach (op_seen[i]) op_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // directed: empty-table errors, bad positions, extremes, first-match search, spare codes
    put(OP_SEARCH, 1, 0);
    put(OP_READ, 1, 0);
    put(OP_DELETE, 1, 0);
    put(OP_WRITE, 1, 32'sh1234_5678);
    put(OP_INSERT, 0, 5);
    put(OP_INSERT, 2, 5);
    put(OP_INSERT, 1, 32'sh8000_0000);
    put(OP_APPEND, 255, 32'sh7FFF_FFFF);
    put(OP_APPEND, 0, -1);
    put(OP_INSERT, 4, 0);
    put(OP_INSERT, 2, 32'sh7FFF_FFFF);
    put(OP_SEARCH, 0, 32'sh7FFF_FFFF);
    put(OP_SEARCH, 1, 12345);
    put(OP_SEARCH, 1, 32'sh8000_0000);
    put(OP_READ, 255, 0);
    put(OP_READ, 0, 0);
    put(OP_READ, 5, 0);
    put(OP_WRITE, 1, 32'sh5555_AAAA);
    put(OP_READ, 1, -1);
    put(OP_DELETE, 6, 0);
    put(OP_DELETE, 2, 0);
    put(OP_SEARCH, 1, 32'sh7FFF_FFFF);
    put(OP_SPARE_A, 1, 32'shFFFF_FFFF);
    put(OP_SPARE_B, 255, 0);
    put(OP_READ, 4, 0);

    // random: stretches of mixed beats with full fill and drain passes between them
    while (op_queue.size() < ITEM_GOAL) begin
      repeat (380) begin
        if (op_queue.size() < ITEM_GOAL) put_mixed();
      end
      if (op_queue.size() < ITEM_GOAL - 300) put_fill_drain();
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() > 0 || in_ch.valid) @(posedge clk);
    while (results_got != beats_in) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("ran %0d beats: append %0d, search %0d (%0d hits), insert %0d, delete %0d,",
             beats_in, op_seen[OP_APPEND], op_seen[OP_SEARCH], search_hits,
             op_seen[OP_INSERT], op_seen[OP_DELETE]);
    $display("  write %0d, read %0d, spare %0d", op_seen[OP_WRITE], op_seen[OP_READ],
             op_seen[OP_SPARE_A] + op_seen[OP_SPARE_B]);
    $display("status ok %0d, bad position %0d, full %0d, empty %0d; table peaked at %0d entries",
             status_seen[ST_OK], status_seen[ST_BADPOS], status_seen[ST_FULL],
             status_seen[ST_EMPTY], peak_count);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
